// ===== src/pwe_pkg.sv =====
// Shared definitions for the path waypoint extractor.
// Register widths, config indexes, reset values and the controller/datapath
// command and status structs. No dependencies.
package pwe_pkg;

    localparam int COORD_BITS_DFLT    = 24;
    localparam int TOL_FRAC_BITS_DFLT = 8;

    localparam int LEN_BITS     = 32;
    localparam int TOL_BITS     = 16;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_STEP = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CURB_TOL = 1'd1;

    localparam logic [LEN_BITS-1:0] MAX_STEP_RST = '1;
    localparam logic [TOL_BITS-1:0] CURB_TOL_RST = 16'd26;

    // controller -> datapath
    typedef struct packed {
        logic capture;      // latch incoming point
        logic init_first;   // path start: current = anchor = point, length = 0
        logic diff;         // register coordinate difference magnitudes
        logic sq_x;         // square x differences
        logic sq_y;         // square y differences
        logic root_load;    // load both root units with sums of squares
        logic root_step;    // one bit of both roots
        logic acc;          // accumulate step length, form detour bound
        logic clr_anchor;   // waypoint taken: move anchor, clear length
        logic out_load;     // load output register
        logic out_final;    // is_final bit for out_load
    } t_pwe_cmd;

    // datapath -> controller
    typedef struct packed {
        logic wp;           // waypoint condition on current length
        logic out_free;     // output register can take a request this cycle
    } t_pwe_sts;

endpackage

// ===== src/pwe_isqrt.sv =====
// Bit-serial floor square root, one root bit per step.
// Depends on nothing; instanced by pwe_datapath.
module pwe_isqrt #(
    parameter int ROOT_BITS = 25
) (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic                     i_step,
    input  logic [2*ROOT_BITS-1:0]   i_radicand,
    output logic [ROOT_BITS-1:0]     o_root
);

    localparam int RAD_BITS = 2 * ROOT_BITS;
    localparam int SH_BITS  = ROOT_BITS + 3;

    logic [RAD_BITS-1:0]  r_rad,  n_rad;
    logic [ROOT_BITS:0]   r_rem,  n_rem;
    logic [ROOT_BITS-1:0] r_root, n_root;

    logic [SH_BITS-1:0] rem_sh;
    logic [SH_BITS-1:0] trial;
    logic [SH_BITS-1:0] rem_sub;
    logic               fits;

    assign rem_sh  = {r_rem, r_rad[RAD_BITS-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign rem_sub = rem_sh - trial;
    assign fits    = rem_sh >= trial;

    always_comb begin
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_load) begin
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (i_step) begin
            n_rad  = {r_rad[RAD_BITS-3:0], 2'b00};
            n_rem  = fits ? rem_sub[ROOT_BITS:0] : rem_sh[ROOT_BITS:0];
            n_root = {r_root[ROOT_BITS-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_root = r_root;

endmodule

// ===== src/pwe_datapath.sv =====
// Datapath: point/anchor/length registers, squares, two root units,
// detour bound, config registers and the output register.
// Depends on pwe_pkg and pwe_isqrt.
module pwe_datapath #(
    parameter int COORD_BITS    = pwe_pkg::COORD_BITS_DFLT,
    parameter int TOL_FRAC_BITS = pwe_pkg::TOL_FRAC_BITS_DFLT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pwe_pkg::t_pwe_cmd                 i_cmd,
    output pwe_pkg::t_pwe_sts                 o_sts,
    input  logic signed [COORD_BITS-1:0]      i_point_x,
    input  logic signed [COORD_BITS-1:0]      i_point_y,
    input  logic                              i_cfg_we,
    input  logic [pwe_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [pwe_pkg::LEN_BITS-1:0]      i_cfg_data,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic signed [COORD_BITS-1:0]      o_waypoint_x,
    output logic signed [COORD_BITS-1:0]      o_waypoint_y,
    output logic                              o_is_final
);

    localparam int C      = COORD_BITS;
    localparam int F      = TOL_FRAC_BITS;
    localparam int LB     = pwe_pkg::LEN_BITS;
    localparam int RB     = C + 1;
    localparam int SQ_W   = 2 * C;
    localparam int RAD_W  = 2 * RB;
    localparam int TW     = ((F > pwe_pkg::TOL_BITS) ? F : pwe_pkg::TOL_BITS) + 1;
    localparam int RHS_W  = TW + RB;
    localparam int CW     = (RHS_W > LB + F) ? RHS_W : LB + F;

    function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
        logic [C:0] d;
        logic [C:0] nd;
        begin
            d  = {a[C-1], a} - {b[C-1], b};
            nd = ~d + 1'b1;
            abs_diff = d[C] ? nd[C-1:0] : d[C-1:0];
        end
    endfunction

    logic signed [C-1:0] r_px, r_py, r_cur_x, r_cur_y, r_anc_x, r_anc_y;
    logic [LB-1:0]       r_len;
    logic [C-1:0]        r_mag_ax, r_mag_ay, r_mag_sx, r_mag_sy;
    logic [SQ_W-1:0]     r_sqa_x, r_sqa_y, r_sqs_x, r_sqs_y;
    logic [RHS_W-1:0]    r_rhs;
    logic [LB-1:0]       r_max_step;
    logic [pwe_pkg::TOL_BITS-1:0] r_tol;
    logic                r_out_valid;
    logic signed [C-1:0] r_wp_x, r_wp_y;
    logic                r_final;

    logic [C-1:0]     mul_a, mul_s;
    logic [SQ_W-1:0]  prod_a, prod_s;
    logic [RAD_W-1:0] rad_a, rad_s;
    logic [RB-1:0]    root_a, root_s;
    logic [LB:0]      len_sum;
    logic [TW-1:0]    scale;
    logic [CW-1:0]    lhs, rhs;

    // shared squarers: x differences first, then y
    assign mul_a  = i_cmd.sq_y ? r_mag_ay : r_mag_ax;
    assign mul_s  = i_cmd.sq_y ? r_mag_sy : r_mag_sx;
    assign prod_a = SQ_W'(mul_a) * SQ_W'(mul_a);
    assign prod_s = SQ_W'(mul_s) * SQ_W'(mul_s);

    assign rad_a = RAD_W'(r_sqa_x) + RAD_W'(r_sqa_y);
    assign rad_s = RAD_W'(r_sqs_x) + RAD_W'(r_sqs_y);

    pwe_isqrt #(.ROOT_BITS(RB)) u_root_anchor (
        .i_clk      (i_clk),
        .i_load     (i_cmd.root_load),
        .i_step     (i_cmd.root_step),
        .i_radicand (rad_a),
        .o_root     (root_a)
    );

    pwe_isqrt #(.ROOT_BITS(RB)) u_root_step (
        .i_clk      (i_clk),
        .i_load     (i_cmd.root_load),
        .i_step     (i_cmd.root_step),
        .i_radicand (rad_s),
        .o_root     (root_s)
    );

    assign len_sum = {1'b0, r_len} + (LB+1)'(root_s);
    assign scale   = (TW'(1) << F) + TW'(r_tol);

    // exact detour test: len * 2^F > (2^F + tol) * straight
    assign lhs = CW'(r_len) << F;
    assign rhs = CW'(r_rhs);

    assign o_sts.wp       = (r_len > r_max_step) || (lhs > rhs);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_px <= i_point_x;
            r_py <= i_point_y;
        end
        if (i_cmd.init_first) begin
            r_cur_x <= r_px;
            r_cur_y <= r_py;
            r_anc_x <= r_px;
            r_anc_y <= r_py;
            r_len   <= '0;
        end
        if (i_cmd.diff) begin
            r_mag_ax <= abs_diff(r_anc_x, r_px);
            r_mag_ay <= abs_diff(r_anc_y, r_py);
            r_mag_sx <= abs_diff(r_cur_x, r_px);
            r_mag_sy <= abs_diff(r_cur_y, r_py);
        end
        if (i_cmd.sq_x) begin
            r_sqa_x <= prod_a;
            r_sqs_x <= prod_s;
        end
        if (i_cmd.sq_y) begin
            r_sqa_y <= prod_a;
            r_sqs_y <= prod_s;
        end
        if (i_cmd.acc) begin
            r_len   <= len_sum[LB] ? '1 : len_sum[LB-1:0];
            r_cur_x <= r_px;
            r_cur_y <= r_py;
            r_rhs   <= RHS_W'(scale) * RHS_W'(root_a);
        end
        if (i_cmd.clr_anchor) begin
            r_anc_x <= r_px;
            r_anc_y <= r_py;
            r_len   <= '0;
        end
        if (i_cmd.out_load) begin
            r_wp_x  <= r_px;
            r_wp_y  <= r_py;
            r_final <= i_cmd.out_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_max_step  <= pwe_pkg::MAX_STEP_RST;
            r_tol       <= pwe_pkg::CURB_TOL_RST;
        end else begin
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pwe_pkg::CFG_MAX_STEP: r_max_step <= i_cfg_data;
                    pwe_pkg::CFG_CURB_TOL: r_tol <= i_cfg_data[pwe_pkg::TOL_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_waypoint_x = r_wp_x;
    assign o_waypoint_y = r_wp_y;
    assign o_is_final   = r_final;

endmodule

// ===== src/pwe_ctrl.sv =====
// Controller: sequences one path point through the datapath and pushes up
// to two requests into the output register. Depends on pwe_pkg.
module pwe_ctrl #(
    parameter int ROOT_STEPS = pwe_pkg::COORD_BITS_DFLT + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_end_of_path,
    output logic              o_in_stall,
    output pwe_pkg::t_pwe_cmd o_cmd,
    input  pwe_pkg::t_pwe_sts i_sts
);

    localparam int CNT_W = $clog2(ROOT_STEPS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FIRST    = 4'd1;
    localparam logic [3:0] S_DIFF     = 4'd2;
    localparam logic [3:0] S_SQX      = 4'd3;
    localparam logic [3:0] S_SQY      = 4'd4;
    localparam logic [3:0] S_RLOAD    = 4'd5;
    localparam logic [3:0] S_ROOT     = 4'd6;
    localparam logic [3:0] S_ACC      = 4'd7;
    localparam logic [3:0] S_TEST     = 4'd8;
    localparam logic [3:0] S_PUSH_WP  = 4'd9;
    localparam logic [3:0] S_PUSH_FIN = 4'd10;

    logic [3:0]       r_state, n_state;
    logic             r_first, n_first;
    logic             r_last,  n_last;
    logic [CNT_W-1:0] r_cnt,   n_cnt;

    always_comb begin
        n_state    = r_state;
        n_first    = r_first;
        n_last     = r_last;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_last        = i_end_of_path;
                    n_state       = r_first ? S_FIRST : S_DIFF;
                end
            end
            S_FIRST: begin
                o_cmd.init_first = 1'b1;
                n_first          = 1'b0;
                n_state          = r_last ? S_PUSH_FIN : S_IDLE;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_SQX;
            end
            S_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state    = S_SQY;
            end
            S_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state    = S_RLOAD;
            end
            S_RLOAD: begin
                o_cmd.root_load = 1'b1;
                n_cnt           = CNT_W'(ROOT_STEPS - 1);
                n_state         = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_ACC;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_TEST;
            end
            S_TEST: begin
                if (i_sts.wp) begin
                    o_cmd.clr_anchor = 1'b1;
                    n_state          = S_PUSH_WP;
                end else begin
                    n_state = r_last ? S_PUSH_FIN : S_IDLE;
                end
            end
            S_PUSH_WP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = r_last ? S_PUSH_FIN : S_IDLE;
                end
            end
            S_PUSH_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_final = 1'b1;
                    n_first         = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b1;
            r_last  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
            r_last  <= n_last;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== src/path_waypoint_extractor.sv =====
// Path waypoint extractor: top level, controller plus datapath.
// Depends on pwe_pkg, pwe_ctrl, pwe_datapath (and pwe_isqrt below it).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one path point per request,
//   with i_end_of_path on the final point of a path. Output channel
//   (o_out_valid / i_out_stall) gives 0..2 waypoint requests per point: an
//   intermediate waypoint first, then the final one (o_is_final = 1).
//   Config: i_cfg_we writes max_step (index 0) or the detour tolerance
//   (index 1); write only while the block is idle.
// Timing:
//   The first point of a path runs capture and init only. Any later point runs
//   difference, squaring of x then y, a root load and COORD_BITS+1 root
//   steps (both roots in parallel), accumulate and test. The next point is
//   taken in the cycle after the last result enters the output register,
//   or in the cycle after init or test when there is none. A new point is
//   never taken while one is in flight; the bit-serial root loop sets the pace.
// Reset: synchronous, active low; config returns to max_step = 2^32-1,
//   tolerance = 26; the next point starts a new path. No clearing pass.
// Stall: a held result stays in the output register; the controller waits
//   for the output register before pushing the next result, while input
//   is taken again once the point is done.
module path_waypoint_extractor #(
    parameter int COORD_BITS    = pwe_pkg::COORD_BITS_DFLT,
    parameter int TOL_FRAC_BITS = pwe_pkg::TOL_FRAC_BITS_DFLT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [COORD_BITS-1:0]      i_point_x,
    input  logic signed [COORD_BITS-1:0]      i_point_y,
    input  logic                              i_end_of_path,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [COORD_BITS-1:0]      o_waypoint_x,
    output logic signed [COORD_BITS-1:0]      o_waypoint_y,
    output logic                              o_is_final,
    input  logic                              i_cfg_we,
    input  logic [pwe_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [pwe_pkg::LEN_BITS-1:0]      i_cfg_data
);

    pwe_pkg::t_pwe_cmd s_cmd;
    pwe_pkg::t_pwe_sts s_sts;

    pwe_ctrl #(.ROOT_STEPS(COORD_BITS + 1)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_end_of_path (i_end_of_path),
        .o_in_stall    (o_in_stall),
        .o_cmd         (s_cmd),
        .i_sts         (s_sts)
    );

    pwe_datapath #(
        .COORD_BITS    (COORD_BITS),
        .TOL_FRAC_BITS (TOL_FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .o_sts        (s_sts),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_waypoint_x (o_waypoint_x),
        .o_waypoint_y (o_waypoint_y),
        .o_is_final   (o_is_final)
    );

    // never overwrite a request the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.out_load |-> s_sts.out_free)
        else $error("output register overwritten");

    // one point at a time: an accepted point blocks input on the next cycle
    a_one_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a point is in flight");

    // the root steps run only after a load or another step
    a_root_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.root_step |-> ($past(s_cmd.root_load) || $past(s_cmd.root_step)))
        else $error("root step without load");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for path_waypoint_extractor: drives path points and register writes,
// predicts waypoints in a scoreboard class and checks every output request.
// Depends on pwe_pkg and the path_waypoint_extractor RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int CW           = pwe_pkg::COORD_BITS_DFLT;
    localparam int FB           = pwe_pkg::TOL_FRAC_BITS_DFLT;
    localparam int LB           = pwe_pkg::LEN_BITS;
    localparam int TB           = pwe_pkg::TOL_BITS;
    localparam int IB           = pwe_pkg::CFG_IDX_BITS;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 500000;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   fin;
    } t_waypoint;

    localparam t_coord C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam t_coord C_MAX = {1'b0, {(CW-1){1'b1}}};

    class waypoint_scoreboard;
        t_waypoint             expected_q[$];
        int                    errors;
        bit                    first_pending;
        t_coord                cur_x, cur_y, anc_x, anc_y;
        logic [LB-1:0]         run_len;
        logic [LB-1:0]         max_step;
        logic [TB-1:0]         curb_tol;

        function new();
            errors        = 0;
            first_pending = 1'b1;
            cur_x         = '0;
            cur_y         = '0;
            anc_x         = '0;
            anc_y         = '0;
            run_len       = '0;
            max_step      = pwe_pkg::MAX_STEP_RST;
            curb_tol      = pwe_pkg::CURB_TOL_RST;
        endfunction

        function void set_reg(logic [IB-1:0] idx, logic [LB-1:0] data);
            case (idx)
                pwe_pkg::CFG_MAX_STEP: max_step = data;
                pwe_pkg::CFG_CURB_TOL: curb_tol = data[TB-1:0];
                default: ;
            endcase
        endfunction

        // floor(sqrt(v)), one result bit per pass
        function logic [63:0] floor_root(logic [63:0] v);
            logic [63:0] rem, root, probe;
            rem   = v;
            root  = '0;
            probe = 64'd1 << 62;
            while (probe > rem) probe = probe >> 2;
            while (probe != 0) begin
                if (rem >= root + probe) begin
                    rem  = rem - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root;
        endfunction

        function logic [63:0] span(t_coord ax, t_coord ay, t_coord bx, t_coord by);
            longint dx, dy;
            dx = longint'(ax) - longint'(bx);
            dy = longint'(ay) - longint'(by);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            return floor_root(64'(dx * dx) + 64'(dy * dy));
        endfunction

        function void push(t_coord x, t_coord y, logic fin);
            t_waypoint w;
            w.x   = x;
            w.y   = y;
            w.fin = fin;
            expected_q.insert(expected_q.size(), w);
        endfunction

        function void note_point(t_coord px, t_coord py, logic eop);
            logic [63:0]         straight, stride, total, lhs, rhs;
            if (first_pending) begin
                first_pending = 1'b0;
                cur_x   = px;
                cur_y   = py;
                anc_x   = px;
                anc_y   = py;
                run_len = '0;
            end else begin
                straight = span(anc_x, anc_y, px, py);
                stride   = span(cur_x, cur_y, px, py);
                total    = 64'(run_len) + stride;
                run_len  = (total > 64'hFFFF_FFFF) ? '1 : total[LB-1:0];
                cur_x    = px;
                cur_y    = py;
                lhs      = 64'(run_len) << FB;
                rhs      = ((64'd1 << FB) + 64'(curb_tol)) * straight;
                if (run_len > max_step || lhs > rhs) begin
                    anc_x   = cur_x;
                    anc_y   = cur_y;
                    run_len = '0;
                    push(cur_x, cur_y, 1'b0);
                end
            end
            if (eop) begin
                push(cur_x, cur_y, 1'b1);
                first_pending = 1'b1;
            end
        endfunction

        function void check_result(t_coord x, t_coord y, logic fin);
            t_waypoint want;
            if (expected_q.size() == 0) begin
                $display("%0t: waypoint expected none, got x=%0d y=%0d final=%0b",
                         $time, x, y, fin);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (x !== want.x) begin
                $display("%0t: waypoint_x expected %0d, got %0d",
                         $time, $signed(want.x), x);
                errors++;
            end
            if (y !== want.y) begin
                $display("%0t: waypoint_y expected %0d, got %0d",
                         $time, $signed(want.y), y);
                errors++;
            end
            if (fin !== want.fin) begin
                $display("%0t: is_final expected %0b, got %0b", $time, want.fin, fin);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    t_coord                  i_point_x;
    t_coord                  i_point_y;
    logic                    i_end_of_path;
    logic                    o_out_valid;
    logic                    i_out_stall;
    t_coord                  o_waypoint_x;
    t_coord                  o_waypoint_y;
    logic                    o_is_final;
    logic                    i_cfg_we;
    logic [IB-1:0]           i_cfg_idx;
    logic [LB-1:0]           i_cfg_data;

    waypoint_scoreboard wp_board;
    bit                 rx_idle;
    bit                 tx_idle_en;
    bit                 hold_req;
    int                 cycle_cnt;

    path_waypoint_extractor u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_end_of_path (i_end_of_path),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_waypoint_x  (o_waypoint_x),
        .o_waypoint_y  (o_waypoint_y),
        .o_is_final    (o_is_final),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int burst;
        int hold;
        burst       = 0;
        hold        = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold     = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                hold--;
                i_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(0, 8);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // output monitor
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                wp_board.check_result(o_waypoint_x, o_waypoint_y, o_is_final);
        end
    end

    function automatic int rand_delta(int k);
        return int'($urandom_range(0, (2 << k) - 1)) - (1 << k);
    endfunction

    // One request on the input channel; valid stays high on return.
    task automatic send_point(t_coord x, t_coord y, logic eop, bit idle);
        if (idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_point_x     <= x;
        i_point_y     <= y;
        i_end_of_path <= eop;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        wp_board.note_point(x, y, eop);
    endtask

    // Stop sending, let all waypoints out, then let the block go idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (wp_board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [LB-1:0] step_lim, logic [LB-1:0] tol_word);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= pwe_pkg::CFG_MAX_STEP;
        i_cfg_data <= step_lim;
        @(posedge i_clk);
        wp_board.set_reg(pwe_pkg::CFG_MAX_STEP, step_lim);
        i_cfg_idx  <= pwe_pkg::CFG_CURB_TOL;
        i_cfg_data <= tol_word;
        @(posedge i_clk);
        wp_board.set_reg(pwe_pkg::CFG_CURB_TOL, tol_word);
        i_cfg_we   <= 1'b0;
    endtask

    // Random walks of varying scale, with repeats, jumps and single-point paths.
    task automatic run_paths(int n_items);
        int     sent, len, k, sel;
        bit     path_idle;
        t_coord px, py;
        sent = 0;
        while (sent < n_items) begin
            len       = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
            k         = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 23);
            path_idle = tx_idle_en && ($urandom_range(0, 2) != 0);
            px        = t_coord'($urandom());
            py        = t_coord'($urandom());
            for (int i = 0; i < len; i++) begin
                if (i > 0) begin
                    sel = $urandom_range(0, 9);
                    if (sel == 1) begin
                        px = t_coord'($urandom());
                        py = t_coord'($urandom());
                    end else if (sel != 0) begin
                        px = t_coord'(int'(px) + rand_delta(k));
                        py = t_coord'(int'(py) + rand_delta(k));
                    end
                end
                send_point(px, py, logic'(i == len - 1), path_idle);
            end
            sent += len;
        end
    endtask

    // Bounce between far corners so the running length saturates.
    task automatic run_long_path(int n);
        t_coord px, py;
        send_point(C_MIN, C_MIN, 1'b0, 1'b0);
        for (int i = 1; i < n; i++) begin
            if (i % 2 == 1) begin
                px = C_MAX - t_coord'($urandom_range(0, 1000));
                py = C_MIN + t_coord'($urandom_range(0, 1000));
            end else begin
                px = C_MIN + t_coord'($urandom_range(0, 1000));
                py = C_MAX - t_coord'($urandom_range(0, 1000));
            end
            send_point(px, py, logic'(i == n - 1), bit'($urandom_range(0, 3) == 0));
        end
    endtask

    // Steps well above a small max_step: every point after the first is a waypoint.
    task automatic run_dense_path(int n);
        t_coord px, py;
        px = t_coord'($urandom());
        py = t_coord'($urandom());
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                px = t_coord'(int'(px) + 1000 + int'($urandom_range(0, 500)));
                py = t_coord'(int'(py) - 1000 - int'($urandom_range(0, 500)));
            end
            send_point(px, py, logic'(i == n - 1), 1'b0);
        end
    endtask

    initial begin
        wp_board      = new();
        rx_idle       = 1'b1;
        tx_idle_en    = 1'b1;
        hold_req      = 1'b0;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_point_x     = '0;
        i_point_y     = '0;
        i_end_of_path = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = pwe_pkg::CFG_MAX_STEP;
        i_cfg_data    = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: single-point path at the coordinate extremes
        send_point(C_MIN, C_MAX, 1'b1, 1'b1);
        // straight diagonal corner to corner: final only
        send_point(C_MIN, C_MIN, 1'b0, 1'b1);
        send_point(C_MAX, C_MAX, 1'b1, 1'b1);
        // detour forces a waypoint mid path
        send_point(t_coord'(0), t_coord'(0), 1'b0, 1'b1);
        send_point(t_coord'(100), t_coord'(0), 1'b0, 1'b1);
        send_point(t_coord'(100), t_coord'(100), 1'b0, 1'b1);
        send_point(t_coord'(0), t_coord'(100), 1'b1, 1'b1);
        // back onto the anchor, on the final point: emitted twice
        send_point(t_coord'(5), t_coord'(5), 1'b0, 1'b1);
        send_point(t_coord'(10), t_coord'(5), 1'b0, 1'b1);
        send_point(t_coord'(5), t_coord'(5), 1'b1, 1'b1);
        // duplicates
        send_point(t_coord'(7), t_coord'(7), 1'b0, 1'b1);
        send_point(t_coord'(7), t_coord'(7), 1'b0, 1'b1);
        send_point(t_coord'(7), t_coord'(7), 1'b1, 1'b1);
        // sign boundaries
        send_point(t_coord'(-1), t_coord'(0), 1'b0, 1'b1);
        send_point(t_coord'(0), t_coord'(-1), 1'b0, 1'b1);
        send_point(C_MIN, C_MAX, 1'b0, 1'b1);
        send_point(C_MAX, C_MIN, 1'b1, 1'b1);
        settle();

        // both registers at their minimum
        write_regs('0, '0);
        send_point(t_coord'(1), t_coord'(2), 1'b0, 1'b1);
        send_point(t_coord'(1), t_coord'(3), 1'b0, 1'b1);
        send_point(t_coord'(1), t_coord'(3), 1'b0, 1'b1);
        send_point(t_coord'(2), t_coord'(3), 1'b1, 1'b1);
        settle();

        // saturation: max tolerance, max_step one below the ceiling
        write_regs(32'hFFFF_FFFE, {16'($urandom()), 16'hFFFF});
        run_long_path(190);
        settle();

        write_regs('1, '0);
        run_paths(70);
        settle();

        // fill the block against a long receiver hold-off
        write_regs(LB'($urandom_range(0, 300)), $urandom());
        hold_req = 1'b1;
        run_dense_path(12);
        run_paths(60);
        settle();

        write_regs(LB'($urandom_range(1, 1 << 20)), $urandom());
        run_paths(70);
        settle();

        write_regs($urandom(), {16'($urandom()), 16'hFFFF});
        run_paths(70);
        settle();

        // last stretch at full rate on both sides
        rx_idle    = 1'b0;
        tx_idle_en = 1'b0;
        write_regs(pwe_pkg::MAX_STEP_RST, LB'(pwe_pkg::CURB_TOL_RST));
        run_paths(80);
        settle();

        if (wp_board.errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/pwe_pkg.sv
src/pwe_isqrt.sv
src/pwe_datapath.sv
src/pwe_ctrl.sv
src/path_waypoint_extractor.sv
sim/tb_top.sv
